### rtl/pon_ubal_pkg.sv
`default_nettype none
package pon_ubal_pkg;

   localparam int NUM_TERMINALS_DEFAULT = 16;
   localparam int MAX_ENTRIES = 16;
   localparam int NUM_CLASSES = 3;
   localparam int BUDGET_W = 16;
   localparam int POOL_W = 24;
   localparam logic [16:0] MAX_OFFSET = 17'h1FFFF;

   // Configuration register indexes
   localparam logic [2:0] CSR_FRAME_BYTES = 3'd0;
   localparam logic [2:0] CSR_WINDOW_A = 3'd1;
   localparam logic [2:0] CSR_WINDOW_B = 3'd2;
   localparam logic [2:0] CSR_WINDOW_C = 3'd3;
   localparam logic [2:0] CSR_INTERVAL_A = 3'd4;
   localparam logic [2:0] CSR_INTERVAL_B = 3'd5;
   localparam logic [2:0] CSR_INTERVAL_C = 3'd6;
   localparam logic [2:0] CSR_GUARD = 3'd7;

   localparam logic [15:0] FRAME_BYTES_RESET = 16'd38880;
   localparam logic [15:0] WINDOW_RESET = 16'd4096;
   localparam logic [11:0] INTERVAL_RESET = 12'd4;
   localparam logic [7:0] GUARD_RESET = 8'd3;

   // Class flag bit positions
   localparam int FL_POLL = 0;
   localparam int FL_EXTRA = 1;
   localparam int FL_PEND = 2;
   localparam int FL_REQ = 3;
   localparam int FL_KIND = 4;

   localparam logic CMD_REPORT = 1'b0;

   typedef enum logic [1:0] {
      UPD_REPORT,
      UPD_SERVE,
      UPD_REFILL
   } upd_op_type;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  terminal;
      logic [1:0]  traffic_class;
      logic [23:0] request_bytes;
      logic        report_kind;
   } req_type;

   typedef struct packed {
      logic [3:0]  map_terminal;
      logic [16:0] start_offset;
      logic [15:0] grant_a;
      logic [15:0] grant_b;
      logic [15:0] grant_c;
      logic [15:0] grant_best_effort;
      logic [2:0]  report_request_mask;
      logic [2:0]  report_kind_mask;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [23:0]        backlog;
      logic signed [17:0] credit;
      logic [11:0]        timer;
      logic [23:0]        gsp;
      logic [23:0]        gse;
      logic [6:0]         flags;
   } entry_type;

   typedef struct packed {
      logic [2:0][15:0] grant;
      logic [2:0]       reqm;
      logic [2:0]       kindm;
      logic [16:0]      offset;
   } map_type;

   typedef struct packed {
      upd_op_type          op;
      logic [15:0]         window;
      logic [11:0]         interval;
      logic [15:0]         budget;
      logic [POOL_W-1:0]   pool;
      logic                report_kind;
      logic [23:0]         request_bytes;
   } upd_ctl_type;

   typedef struct packed {
      logic [15:0]       grant;
      logic [15:0]       budget;
      logic [POOL_W-1:0] pool;
      logic              req_bit;
      logic              kind_bit;
   } upd_res_type;

   localparam entry_type ENTRY_RESET = '{
      backlog: 24'd0,
      credit: 18'sd4096,
      timer: 12'd3,
      gsp: 24'd0,
      gse: 24'd0,
      flags: 7'b1000000
   };

   function automatic logic [23:0] sat24(input logic [23:0] a, input logic [15:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {9'd0, b};
      return s[24] ? 24'hFFFFFF : s[23:0];
   endfunction

   // Credit that an expired, positive bucket lends to the class pool
   function automatic logic [POOL_W-1:0] contrib(input entry_type e);
      logic [POOL_W-1:0] r;
      r = '0;
      if (e.timer == 12'd0 && e.credit > 0) begin
         r = POOL_W'(e.credit[16:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/pon_ubal_ram.sv
`default_nettype none
module pon_ubal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

### rtl/pon_ubal_update.sv
`default_nettype none
module pon_ubal_update (
   input  wire pon_ubal_pkg::upd_ctl_type ctl,
   input  wire pon_ubal_pkg::entry_type   entry_in,
   output      pon_ubal_pkg::entry_type   entry_out,
   output      pon_ubal_pkg::upd_res_type res
);

   pon_ubal_pkg::entry_type e;
   logic [4:0]         fl;
   logic [1:0]         cnt;
   logic               expired;
   logic [15:0]        g;
   logic [15:0]        m;
   logic [23:0]        used;
   logic signed [25:0] s;

   always_comb begin
      e = entry_in;
      fl = entry_in.flags[4:0];
      cnt = entry_in.flags[6:5];
      expired = (entry_in.timer == 12'd0);
      g = '0;
      m = '0;
      used = '0;
      s = '0;
      res.budget = ctl.budget;
      case (ctl.op)
         pon_ubal_pkg::UPD_REPORT: begin
            if (ctl.report_kind) begin
               used = e.gse;
               e.gse = '0;
               fl[pon_ubal_pkg::FL_EXTRA] = 1'b0;
            end else begin
               used = e.gsp;
               e.gsp = '0;
               fl[pon_ubal_pkg::FL_POLL] = 1'b0;
            end
            e.backlog = (ctl.request_bytes > used) ? ctl.request_bytes - used : '0;
         end
         pon_ubal_pkg::UPD_SERVE: begin
            if (expired) begin
               fl[pon_ubal_pkg::FL_REQ] = 1'b1;
               fl[pon_ubal_pkg::FL_POLL] = 1'b1;
               fl[pon_ubal_pkg::FL_KIND] = 1'b0;
               cnt = 2'd1;
            end else begin
               fl[pon_ubal_pkg::FL_REQ] = 1'b0;
            end
            m = ctl.window;
            if (e.backlog < {8'd0, m}) begin
               m = e.backlog[15:0];
            end
            if (ctl.budget < m) begin
               m = ctl.budget;
            end
            if (e.credit > 0 && ctl.budget != 16'd0) begin
               g = m;
               e.credit = e.credit - $signed({2'b00, g});
               e.backlog = e.backlog - {8'd0, g};
               res.budget = ctl.budget - g;
            end
            if (fl[pon_ubal_pkg::FL_POLL]) begin
               e.gsp = pon_ubal_pkg::sat24(e.gsp, g);
            end
            if (g != 16'd0 && cnt < 2'd2) begin
               fl[pon_ubal_pkg::FL_PEND] = 1'b1;
               cnt = cnt + 2'd1;
            end
            if (!expired && fl[pon_ubal_pkg::FL_PEND]) begin
               fl[pon_ubal_pkg::FL_REQ] = 1'b1;
               fl[pon_ubal_pkg::FL_KIND] = 1'b1;
               fl[pon_ubal_pkg::FL_EXTRA] = 1'b1;
               fl[pon_ubal_pkg::FL_PEND] = 1'b0;
            end
            if (fl[pon_ubal_pkg::FL_EXTRA]) begin
               e.gse = pon_ubal_pkg::sat24(e.gse, g);
            end
         end
         pon_ubal_pkg::UPD_REFILL: begin
            // borrow from the pool of expired positive buckets
            if (e.credit < 0 && ctl.pool != '0) begin
               s = $signed({2'b00, ctl.pool}) + 26'(e.credit);
               e.credit = s[25] ? $signed(s[17:0]) : 18'sd0;
            end
            if (expired) begin
               e.timer = ctl.interval;
               e.credit = (e.credit < 0) ? e.credit + $signed({2'b00, ctl.window})
                                         : $signed({2'b00, ctl.window});
            end
            e.timer = e.timer - 12'd1;
         end
         default: begin
         end
      endcase
      e.flags = {cnt, fl};
      entry_out = e;
      res.grant = g;
      res.req_bit = fl[pon_ubal_pkg::FL_REQ];
      res.kind_bit = fl[pon_ubal_pkg::FL_REQ] & fl[pon_ubal_pkg::FL_KIND];
      res.pool = ctl.pool + pon_ubal_pkg::contrib(e)
                 - ((ctl.op == pon_ubal_pkg::UPD_REFILL) ? pon_ubal_pkg::contrib(entry_in)
                                                         : '0);
   end

endmodule
`default_nettype wire

### rtl/pon_ubal_div.sv
`default_nettype none
module pon_ubal_div #(
   parameter int DIVISOR = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [pon_ubal_pkg::BUDGET_W-1:0] dividend,
   output      logic                              done,
   output      logic [pon_ubal_pkg::BUDGET_W-1:0] quotient
);

   localparam int W = pon_ubal_pkg::BUDGET_W;
   localparam int L = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
   localparam int S = W + L;
   localparam int PW = S + W + 2;
   // ceil(2^S / DIVISOR) gives the exact quotient for every W-bit dividend
   localparam int RECIP = ((1 << S) + DIVISOR - 1) / DIVISOR;

   logic [PW-1:0] prod;
   logic [W-1:0]  q_ff, q_in;
   logic          done_ff, done_in;

   always_comb begin
      prod = PW'(dividend) * PW'(RECIP);
      q_in = start ? prod[S +: W] : q_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

### rtl/pon_upstream_bandwidth_allocator_core.sv
`default_nettype none
// Report: busy while it reads, then modifies and writes back one state entry; no result;
// a dropped report leaves busy low and the next item can transfer on the following edge.
// Frame: busy through a read-modify-write per terminal over the state RAM (serve and refill
// per class), the divide for the best-effort share, the read-modify-write offset walk per
// terminal and one map read per entry for min(NUM_TERMINALS,16) entries.
// Map entries stream out one per cycle with rsp_valid, the last in the cycle busy falls;
// the receiver cannot stall. Reset: synchronous; configuration returns to defaults, state
// entries read as reset.
module pon_upstream_bandwidth_allocator_core #(
   parameter int NUM_TERMINALS = pon_ubal_pkg::NUM_TERMINALS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire pon_ubal_pkg::req_type req_data,
   output      logic                  rsp_valid,
   output      pon_ubal_pkg::rsp_type rsp_data,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [2:0]            csr_index,
   input  wire logic [15:0]           csr_data
);

   localparam int TW = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
   localparam int SDEPTH = 3 * (1 << TW);
   localparam int SAW = TW + 2;
   localparam int MDEPTH = 1 << TW;
   localparam int EMIT_N = (NUM_TERMINALS < pon_ubal_pkg::MAX_ENTRIES) ?
                           NUM_TERMINALS : pon_ubal_pkg::MAX_ENTRIES;
   localparam int EW = $bits(pon_ubal_pkg::entry_type);
   localparam int MW = $bits(pon_ubal_pkg::map_type);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_RPT_RD = 11'b00000000010,
      ST_RPT_WR = 11'b00000000100,
      ST_SRV_RD = 11'b00000001000,
      ST_SRV_WR = 11'b00000010000,
      ST_REF_RD = 11'b00000100000,
      ST_REF_WR = 11'b00001000000,
      ST_DIV    = 11'b00010000000,
      ST_OFS_RD = 11'b00100000000,
      ST_OFS_WR = 11'b01000000000,
      ST_EMIT   = 11'b10000000000
   } fsm_type;

   fsm_type state_ff, state_in;

   // configuration
   logic [15:0] frame_bytes_ff;
   logic [15:0] win_ff [3];
   logic [11:0] ivl_ff [3];
   logic [7:0]  guard_ff;

   // sequencer state
   pon_ubal_pkg::req_type req_ff, req_in;
   logic [TW-1:0]   t_ff, t_in, t_next;
   logic [TW-1:0]   sp_ff, sp_in, sp_next;
   logic [1:0]      c_ff, c_in;
   logic [15:0]     budget_ff, budget_in;
   logic [pon_ubal_pkg::POOL_W-1:0] pool_ff, pool_in;
   logic [15:0]     share_ff, share_in;
   logic [16:0]     acc_ff, acc_in;
   logic [SDEPTH-1:0] valid_ff;
   logic            vld_rd_ff;
   logic            emit_vld_ff, emit_vld_in;
   logic [3:0]      emit_t_ff, emit_t_in;
   logic            emit_last_ff, emit_last_in;
   logic            div_start;

   // memory ports
   logic [SAW-1:0]  s_addr;
   logic            s_re, s_we;
   logic [EW-1:0]   s_rdata;
   logic            m_re, m_we;
   logic [TW-1:0]   m_raddr;
   logic [MW-1:0]   m_rdata;
   pon_ubal_pkg::map_type   m_q, m_wdata;
   pon_ubal_pkg::entry_type ent_q, ent_new;
   pon_ubal_pkg::upd_ctl_type ctl;
   pon_ubal_pkg::upd_res_type res;
   logic [15:0]     div_q;
   logic            div_done;
   logic [19:0]     burst, acc_sum;
   logic            accept;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   // hold configuration transfers off while an item is in flight
   assign csr_ready = !busy;

   assign t_next = (t_ff == TW'(NUM_TERMINALS - 1)) ? '0 : t_ff + TW'(1);
   assign sp_next = (sp_ff == TW'(NUM_TERMINALS - 1)) ? '0 : sp_ff + TW'(1);
   assign s_addr = {c_ff, t_ff};

   // entries never written since reset read as the reset entry
   assign ent_q = vld_rd_ff ? pon_ubal_pkg::entry_type'(s_rdata) : pon_ubal_pkg::ENTRY_RESET;
   assign m_q = pon_ubal_pkg::map_type'(m_rdata);

   always_comb begin
      case (state_ff)
         ST_RPT_WR: ctl.op = pon_ubal_pkg::UPD_REPORT;
         ST_SRV_WR: ctl.op = pon_ubal_pkg::UPD_SERVE;
         default:   ctl.op = pon_ubal_pkg::UPD_REFILL;
      endcase
      ctl.window = win_ff[c_ff];
      ctl.interval = ivl_ff[c_ff];
      ctl.budget = budget_ff;
      ctl.pool = pool_ff;
      ctl.report_kind = req_ff.report_kind;
      ctl.request_bytes = req_ff.request_bytes;
   end

   pon_ubal_update u_update (
      .ctl       (ctl),
      .entry_in  (ent_q),
      .entry_out (ent_new),
      .res       (res)
   );

   pon_ubal_ram #(.WIDTH(EW), .DEPTH(SDEPTH)) u_state_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_addr),
      .wdata (EW'(ent_new)),
      .re    (s_re),
      .raddr (s_addr),
      .rdata (s_rdata)
   );

   pon_ubal_ram #(.WIDTH(MW), .DEPTH(MDEPTH)) u_map_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (t_ff),
      .wdata (MW'(m_wdata)),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   pon_ubal_div #(.DIVISOR(NUM_TERMINALS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (budget_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      burst = 20'(m_q.grant[0]) + 20'(m_q.grant[1]) + 20'(m_q.grant[2])
              + 20'(share_ff) + 20'(guard_ff);
      acc_sum = 20'(acc_ff) + burst;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      t_in = t_ff;
      sp_in = sp_ff;
      c_in = c_ff;
      budget_in = budget_ff;
      pool_in = pool_ff;
      share_in = share_ff;
      acc_in = acc_ff;
      emit_vld_in = 1'b0;
      emit_t_in = emit_t_ff;
      emit_last_in = emit_last_ff;
      div_start = 1'b0;
      s_re = 1'b0;
      s_we = 1'b0;
      m_re = 1'b0;
      m_we = 1'b0;
      m_raddr = t_ff;
      m_wdata = m_q;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.cmd == pon_ubal_pkg::CMD_REPORT) begin
                  t_in = TW'(req_data.terminal);
                  c_in = req_data.traffic_class;
                  // drop reports for absent terminals or the unused class code
                  if (int'(req_data.terminal) < NUM_TERMINALS && req_data.traffic_class != 2'd3)
                  begin
                     state_in = ST_RPT_RD;
                  end
               end else begin
                  budget_in = frame_bytes_ff;
                  c_in = 2'd0;
                  t_in = sp_ff;
                  pool_in = '0;
                  state_in = ST_SRV_RD;
               end
            end
         end
         ST_RPT_RD: begin
            s_re = 1'b1;
            state_in = ST_RPT_WR;
         end
         ST_RPT_WR: begin
            s_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SRV_RD: begin
            s_re = 1'b1;
            m_re = 1'b1;
            state_in = ST_SRV_WR;
         end
         ST_SRV_WR: begin
            s_we = 1'b1;
            m_we = 1'b1;
            m_wdata.grant[c_ff] = res.grant;
            m_wdata.reqm[c_ff] = res.req_bit;
            m_wdata.kindm[c_ff] = res.kind_bit;
            budget_in = res.budget;
            pool_in = res.pool;
            if (t_next == sp_ff) begin
               t_in = sp_ff;
               state_in = ST_REF_RD;
            end else begin
               t_in = t_next;
               state_in = ST_SRV_RD;
            end
         end
         ST_REF_RD: begin
            s_re = 1'b1;
            state_in = ST_REF_WR;
         end
         ST_REF_WR: begin
            s_we = 1'b1;
            pool_in = res.pool;
            if (t_next == sp_ff) begin
               t_in = sp_ff;
               if (c_ff == 2'd2) begin
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  c_in = c_ff + 2'd1;
                  pool_in = '0;
                  state_in = ST_SRV_RD;
               end
            end else begin
               t_in = t_next;
               state_in = ST_REF_RD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               share_in = div_q;
               acc_in = '0;
               state_in = ST_OFS_RD;
            end
         end
         ST_OFS_RD: begin
            m_re = 1'b1;
            state_in = ST_OFS_WR;
         end
         ST_OFS_WR: begin
            m_we = 1'b1;
            m_wdata.offset = acc_ff;
            acc_in = (acc_sum > 20'(pon_ubal_pkg::MAX_OFFSET)) ? pon_ubal_pkg::MAX_OFFSET
                                                               : acc_sum[16:0];
            if (t_next == sp_ff) begin
               t_in = '0;
               state_in = ST_EMIT;
            end else begin
               t_in = t_next;
               state_in = ST_OFS_RD;
            end
         end
         ST_EMIT: begin
            // issue one map read per cycle in terminal order
            m_re = 1'b1;
            emit_vld_in = 1'b1;
            emit_t_in = 4'(t_ff);
            emit_last_in = (t_ff == TW'(EMIT_N - 1));
            if (t_ff == TW'(EMIT_N - 1)) begin
               sp_in = sp_next;
               state_in = ST_IDLE;
            end else begin
               t_in = t_next;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      t_ff <= t_in;
      c_ff <= c_in;
      budget_ff <= budget_in;
      pool_ff <= pool_in;
      share_ff <= share_in;
      acc_ff <= acc_in;
      emit_t_ff <= emit_t_in;
      emit_last_ff <= emit_last_in;
      if (s_re) begin
         vld_rd_ff <= valid_ff[s_addr];
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff <= '0;
         valid_ff <= '0;
         emit_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         emit_vld_ff <= emit_vld_in;
         if (s_we) begin
            valid_ff[s_addr] <= 1'b1;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bytes_ff <= pon_ubal_pkg::FRAME_BYTES_RESET;
         win_ff[0] <= pon_ubal_pkg::WINDOW_RESET;
         win_ff[1] <= pon_ubal_pkg::WINDOW_RESET;
         win_ff[2] <= pon_ubal_pkg::WINDOW_RESET;
         ivl_ff[0] <= pon_ubal_pkg::INTERVAL_RESET;
         ivl_ff[1] <= pon_ubal_pkg::INTERVAL_RESET;
         ivl_ff[2] <= pon_ubal_pkg::INTERVAL_RESET;
         guard_ff <= pon_ubal_pkg::GUARD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pon_ubal_pkg::CSR_FRAME_BYTES: frame_bytes_ff <= csr_data;
            pon_ubal_pkg::CSR_WINDOW_A:    win_ff[0] <= csr_data;
            pon_ubal_pkg::CSR_WINDOW_B:    win_ff[1] <= csr_data;
            pon_ubal_pkg::CSR_WINDOW_C:    win_ff[2] <= csr_data;
            pon_ubal_pkg::CSR_INTERVAL_A:  ivl_ff[0] <= csr_data[11:0];
            pon_ubal_pkg::CSR_INTERVAL_B:  ivl_ff[1] <= csr_data[11:0];
            pon_ubal_pkg::CSR_INTERVAL_C:  ivl_ff[2] <= csr_data[11:0];
            pon_ubal_pkg::CSR_GUARD:       guard_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // result transfer straight from the registered map read
   always_comb begin
      rsp_valid = emit_vld_ff;
      rsp_data.map_terminal = emit_t_ff;
      rsp_data.start_offset = m_q.offset;
      rsp_data.grant_a = m_q.grant[0];
      rsp_data.grant_b = m_q.grant[1];
      rsp_data.grant_c = m_q.grant[2];
      rsp_data.grant_best_effort = share_ff;
      rsp_data.report_request_mask = m_q.reqm;
      rsp_data.report_kind_mask = m_q.kindm;
      rsp_data.last = emit_last_ff;
   end

endmodule
`default_nettype wire

### tb/sv/pon_upstream_bandwidth_allocator_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module pon_upstream_bandwidth_allocator_core_tb;

   localparam int NT = 16;
   // Sized for the worst frame; leave margin for the drain
   localparam int FRAME_CYCLES = 14 * NT + NT + 1;
   localparam int DRAIN_CYCLES = FRAME_CYCLES + 40;

   // Bandwidth map predictor plus the queue of map entries still owed by the block
   class map_scoreboard;
      int unsigned frame_bytes, guard;
      int unsigned win[3];
      int unsigned ivl[3];
      int unsigned backlog[NT][3];
      int          credit[NT][3];
      int unsigned timer[NT][3];
      int unsigned gsp[NT][3];
      int unsigned gse[NT][3];
      logic [6:0]  flags[NT][3];
      int unsigned fgrant[NT][3];
      int unsigned sp;
      pon_ubal_pkg::rsp_type pending_map[$];
      int          errors, checked, frames, reports;

      function new();
         frame_bytes = pon_ubal_pkg::FRAME_BYTES_RESET;
         guard = pon_ubal_pkg::GUARD_RESET;
         for (int c = 0; c < 3; c++) begin
            win[c] = pon_ubal_pkg::WINDOW_RESET;
            ivl[c] = pon_ubal_pkg::INTERVAL_RESET;
         end
         for (int t = 0; t < NT; t++) begin
            for (int c = 0; c < 3; c++) begin
               backlog[t][c] = 0;
               credit[t][c] = win[c];
               timer[t][c] = (ivl[c] - 1) & 12'hFFF;
               gsp[t][c] = 0;
               gse[t][c] = 0;
               flags[t][c] = 7'b1000000;
               fgrant[t][c] = 0;
            end
         end
         sp = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            pon_ubal_pkg::CSR_FRAME_BYTES: frame_bytes = val;
            pon_ubal_pkg::CSR_WINDOW_A:    win[0] = val;
            pon_ubal_pkg::CSR_WINDOW_B:    win[1] = val;
            pon_ubal_pkg::CSR_WINDOW_C:    win[2] = val;
            pon_ubal_pkg::CSR_INTERVAL_A:  ivl[0] = val[11:0];
            pon_ubal_pkg::CSR_INTERVAL_B:  ivl[1] = val[11:0];
            pon_ubal_pkg::CSR_INTERVAL_C:  ivl[2] = val[11:0];
            pon_ubal_pkg::CSR_GUARD:       guard = val[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned sat_add24(int unsigned a, int unsigned b);
         return (a + b > 24'hFFFFFF) ? 24'hFFFFFF : a + b;
      endfunction

      // Lend expired positive credit to negative buckets, then reload expired ones
      function void refill(int c);
         int t;
         longint pool, v;
         for (int n = 0; n < NT; n++) begin
            t = (sp + n) % NT;
            pool = 0;
            for (int i = 0; i < NT; i++)
               if (timer[i][c] == 0 && credit[i][c] > 0) pool += credit[i][c];
            if (credit[t][c] < 0 && pool > 0) begin
               pool += credit[t][c];
               credit[t][c] = (pool < 0) ? int'(pool) : 0;
            end
            if (timer[t][c] == 0) begin
               v = longint'(win[c]) + credit[t][c];
               timer[t][c] = ivl[c];
               credit[t][c] = (v < longint'(win[c])) ? int'(v) : int'(win[c]);
            end
            timer[t][c] = (timer[t][c] - 1) & 12'hFFF;
         end
      endfunction

      function int unsigned serve(int c, int unsigned budget);
         int t;
         logic [6:0] fl;
         int unsigned cnt, g;
         bit expired;
         for (int n = 0; n < NT; n++) begin
            t = (sp + n) % NT;
            fl = flags[t][c];
            cnt = fl[6:5];
            expired = (timer[t][c] == 0);
            g = 0;
            if (expired) begin
               fl[pon_ubal_pkg::FL_REQ] = 1'b1;
               fl[pon_ubal_pkg::FL_POLL] = 1'b1;
               fl[pon_ubal_pkg::FL_KIND] = 1'b0;
               cnt = 1;
            end else begin
               fl[pon_ubal_pkg::FL_REQ] = 1'b0;
            end
            if (credit[t][c] > 0 && budget > 0) begin
               g = win[c];
               if (backlog[t][c] < g) g = backlog[t][c];
               if (budget < g) g = budget;
               credit[t][c] -= int'(g);
               backlog[t][c] -= g;
               budget -= g;
            end
            fgrant[t][c] = g;
            if (fl[pon_ubal_pkg::FL_POLL]) gsp[t][c] = sat_add24(gsp[t][c], g);
            if (g > 0 && cnt < 2) begin
               fl[pon_ubal_pkg::FL_PEND] = 1'b1;
               cnt++;
            end
            if (!expired && fl[pon_ubal_pkg::FL_PEND]) begin
               fl[pon_ubal_pkg::FL_REQ] = 1'b1;
               fl[pon_ubal_pkg::FL_KIND] = 1'b1;
               fl[pon_ubal_pkg::FL_EXTRA] = 1'b1;
               fl[pon_ubal_pkg::FL_PEND] = 1'b0;
            end
            if (fl[pon_ubal_pkg::FL_EXTRA]) gse[t][c] = sat_add24(gse[t][c], g);
            fl[6:5] = cnt[1:0];
            flags[t][c] = fl;
         end
         refill(c);
         return budget;
      endfunction

      function void note_item(pon_ubal_pkg::req_type r);
         int unsigned budget, share, acc, used;
         int unsigned offset[NT];
         int t, k;
         pon_ubal_pkg::rsp_type m;
         if (r.cmd == pon_ubal_pkg::CMD_REPORT) begin
            t = r.terminal;
            k = r.traffic_class;
            if (t >= NT || k >= 3) return;
            reports++;
            used = r.report_kind ? gse[t][k] : gsp[t][k];
            if (r.report_kind) begin
               flags[t][k][pon_ubal_pkg::FL_EXTRA] = 1'b0;
               gse[t][k] = 0;
            end else begin
               flags[t][k][pon_ubal_pkg::FL_POLL] = 1'b0;
               gsp[t][k] = 0;
            end
            backlog[t][k] = (r.request_bytes > used) ? r.request_bytes - used : 0;
            return;
         end
         frames++;
         budget = frame_bytes;
         for (int c = 0; c < 3; c++) budget = serve(c, budget);
         share = budget / NT;
         acc = 0;
         for (int n = 0; n < NT; n++) begin
            t = (sp + n) % NT;
            offset[t] = acc;
            acc += fgrant[t][0] + fgrant[t][1] + fgrant[t][2] + share + guard;
            if (acc > pon_ubal_pkg::MAX_OFFSET) acc = pon_ubal_pkg::MAX_OFFSET;
         end
         for (int n = 0; n < pon_ubal_pkg::MAX_ENTRIES && n < NT; n++) begin
            m = '0;
            m.map_terminal = n[3:0];
            m.start_offset = offset[n][16:0];
            m.grant_a = fgrant[n][0][15:0];
            m.grant_b = fgrant[n][1][15:0];
            m.grant_c = fgrant[n][2][15:0];
            m.grant_best_effort = share[15:0];
            for (int c = 0; c < 3; c++) begin
               if (flags[n][c][pon_ubal_pkg::FL_REQ]) begin
                  m.report_request_mask[c] = 1'b1;
                  m.report_kind_mask[c] = flags[n][c][pon_ubal_pkg::FL_KIND];
               end
            end
            m.last = (n + 1 == pon_ubal_pkg::MAX_ENTRIES || n + 1 == NT);
            pending_map.push_back(m);
         end
         sp = (sp + 1) % NT;
      endfunction

      function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(pon_ubal_pkg::rsp_type a);
         pon_ubal_pkg::rsp_type e;
         if (pending_map.size() == 0) begin
            $error("map entry for terminal %0d with nothing expected", a.map_terminal);
            errors++;
            return;
         end
         e = pending_map.pop_front();
         checked++;
         cmp_field("map_terminal", e.map_terminal, a.map_terminal);
         cmp_field("start_offset", e.start_offset, a.start_offset);
         cmp_field("grant_a", e.grant_a, a.grant_a);
         cmp_field("grant_b", e.grant_b, a.grant_b);
         cmp_field("grant_c", e.grant_c, a.grant_c);
         cmp_field("grant_best_effort", e.grant_best_effort, a.grant_best_effort);
         cmp_field("report_request_mask", e.report_request_mask, a.report_request_mask);
         cmp_field("report_kind_mask", e.report_kind_mask, a.report_kind_mask);
         cmp_field("last", e.last, a.last);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   pon_ubal_pkg::req_type req_data;
   logic       rsp_valid;
   pon_ubal_pkg::rsp_type rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   map_scoreboard sb;
   bit            no_gaps;

   pon_upstream_bandwidth_allocator_core #(.NUM_TERMINALS(NT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Sample map entries on the edge that ends their strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   // Present one item after a random gap and hold it until the transfer happens.
   // Start stays high across back-to-back items, so it is only lowered on a gap.
   task automatic drive_item(pon_ubal_pkg::req_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      sb.note_item(item);
   endtask

   // Drop start, then wait for every owed map entry and for any report still in flight
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_map.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(i[2:0], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic pon_ubal_pkg::req_type make_report(int term, int cls, int unsigned bytes,
                                                         bit kind);
      pon_ubal_pkg::req_type r;
      r.cmd = ~pon_ubal_pkg::CMD_REPORT;
      r.cmd = pon_ubal_pkg::CMD_REPORT;
      r.terminal = term[3:0];
      r.traffic_class = cls[1:0];
      r.request_bytes = bytes[23:0];
      r.report_kind = kind;
      return r;
   endfunction

   function automatic pon_ubal_pkg::req_type make_frame();
      pon_ubal_pkg::req_type r;
      r = pon_ubal_pkg::req_type'($urandom);
      r.cmd = ~pon_ubal_pkg::CMD_REPORT;
      return r;
   endfunction

   function automatic int unsigned rand_bytes();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 255);
         1: return $urandom_range(0, 8191);
         2: return $urandom_range(0, 65535);
         default: return $urandom & 24'hFFFFFF;
      endcase
   endfunction

   // Random mix: mostly reports that keep backlog flowing, a frame tick every few items
   task automatic random_items(int count);
      int n;
      pon_ubal_pkg::req_type r;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 59) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 3) == 0) begin
            r = make_frame();
         end else begin
            r = make_report($urandom_range(0, 15), $urandom_range(0, 3), rand_bytes(),
                            $urandom_range(0, 1));
         end
         drive_item(r);
         if (r.cmd != pon_ubal_pkg::CMD_REPORT || r.traffic_class != 2'd3) n++;
      end
   endtask

   initial begin
      logic [15:0] regs[8];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_gaps = 1'b0;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: frame from reset, field extremes, ignored class, extra polls, expiry
      drive_item(make_frame());
      drive_item(make_report(0, 0, 0, 1'b0));
      drive_item(make_report(15, 2, 24'hFFFFFF, 1'b1));
      drive_item(make_report(5, 3, 24'hFFFFFF, 1'b0));
      drive_item(make_report(1, 1, 5000, 1'b0));
      drive_item(make_report(2, 0, 3000, 1'b0));
      drive_item(make_report(3, 2, 100, 1'b0));
      for (int i = 0; i < 4; i++) drive_item(make_frame());
      drive_item(make_report(1, 1, 9000, 1'b1));
      drive_item(make_report(2, 0, 1, 1'b1));
      drive_item(make_report(15, 2, 24'hFFFFFF, 1'b0));
      drive_item(make_report(0, 0, 24'hFFFFFF, 1'b0));
      drive_item(make_report(8, 1, 24'hAAAAAA, 1'b0));
      drive_item(make_report(7, 0, 24'h555555, 1'b1));
      for (int i = 0; i < 5; i++) drive_item(make_frame());
      drain();

      random_items(40);
      drain();

      // Large budget and windows, shortest intervals, widest guard
      regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd255};
      write_regs(regs);
      for (int i = 0; i < 8; i++) begin
         drive_item(make_report(i, i % 3, 24'hFFFFFF, 1'b0));
      end
      random_items(40);
      drain();

      // Empty budget, closed windows, longest intervals, no guard
      regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd4095, 16'd4095, 16'd0};
      write_regs(regs);
      random_items(25);
      drain();

      // Mixed windows with a zero interval so timers wrap
      regs = '{16'd20000, 16'd1000, 16'd3000, 16'hFFFF, 16'd2, 16'd3, 16'd0, 16'd10};
      write_regs(regs);
      random_items(40);
      drain();

      // Random register values
      for (int i = 0; i < 8; i++) regs[i] = $urandom;
      for (int i = 4; i < 7; i++) regs[i] = $urandom_range(1, 6);
      write_regs(regs);
      random_items(40);
      drain();

      $display("Covered %0d reports and %0d frame ticks over five register settings,",
               sb.reports, sb.frames);
      $display("checked %0d map entries.", sb.checked);
      if (sb.errors == 0 && sb.pending_map.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timeout with %0d map entries outstanding", sb.pending_map.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
